>>> rtl/core/pra_pkg.sv
// Shared types and constants for the pedal rolling-average filter.
package pra_pkg;

    localparam int SAMPLE_W      = 10;
    localparam int RUN_W         = 8;
    localparam int LOW_RUN_LIMIT = 4;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [RUN_W-1:0]    run_t;

    localparam run_t RUN_MAX = '1;

    typedef struct packed {
        logic    load;
        sample_t sample;
    } pra_win_ctrl_t;

endpackage

>>> rtl/core/pra_window.sv
// Sample window: shift line of recent samples, running sum and low-run refill.
module pra_window #(
    parameter int  WINDOW_LEN = 8,
    localparam int SUM_W      = pra_pkg::SAMPLE_W + $clog2(WINDOW_LEN)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pra_pkg::pra_win_ctrl_t ctrl,
    input  pra_pkg::sample_t      floor_val,
    output logic [SUM_W-1:0]      sum_pre
);
    import pra_pkg::*;

    sample_t          ring_reg  [WINDOW_LEN];
    sample_t          ring_next [WINDOW_LEN];
    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;
    logic [SUM_W-1:0] sum_mid;
    logic [SUM_W-1:0] refill_sum;
    run_t             run_reg;
    run_t             run_next;
    run_t             run_inc;
    logic             is_low;
    logic             refill;

    // Oldest tap leaves, new sample enters; sum order does not matter.
    always_comb
    begin
        run_inc    = (run_reg == RUN_MAX) ? run_reg : run_reg + 1'b1;
        is_low     = (ctrl.sample <= floor_val);
        refill     = is_low && (run_inc >= RUN_W'(LOW_RUN_LIMIT));
        sum_mid    = sum_reg - SUM_W'(ring_reg[WINDOW_LEN-1]) + SUM_W'(ctrl.sample);
        refill_sum = SUM_W'(SUM_W'(floor_val) * SUM_W'(WINDOW_LEN));
        sum_pre    = sum_mid;
    end

    always_comb
    begin
        run_next = run_reg;
        sum_next = sum_reg;
        for (int i = 0; i < WINDOW_LEN; i++)
        begin
            ring_next[i] = ring_reg[i];
        end
        if (ctrl.load)
        begin
            run_next = is_low ? run_inc : '0;
            if (refill)
            begin
                sum_next = refill_sum;
                for (int i = 0; i < WINDOW_LEN; i++)
                begin
                    ring_next[i] = floor_val;
                end
            end
            else
            begin
                sum_next     = sum_mid;
                ring_next[0] = ctrl.sample;
                for (int i = 1; i < WINDOW_LEN; i++)
                begin
                    ring_next[i] = ring_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= '0;
            sum_reg <= '0;
            for (int i = 0; i < WINDOW_LEN; i++)
            begin
                ring_reg[i] <= '0;
            end
        end
        else
        begin
            run_reg <= run_next;
            sum_reg <= sum_next;
            for (int i = 0; i < WINDOW_LEN; i++)
            begin
                ring_reg[i] <= ring_next[i];
            end
        end
    end

endmodule

>>> rtl/core/pra_div.sv
// Divide the window sum by the window length through a reciprocal multiply.
module pra_div #(
    parameter int  WINDOW_LEN = 8,
    localparam int SUM_W      = pra_pkg::SAMPLE_W + $clog2(WINDOW_LEN)
) (
    input  logic [SUM_W-1:0] sum,
    output pra_pkg::sample_t quot
);
    import pra_pkg::*;

    localparam int SHIFT_L = $clog2(WINDOW_LEN);
    localparam int SHIFT_K = SUM_W + SHIFT_L;
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam longint unsigned RECIP_FULL =
        ((longint'(1) << SHIFT_K) + longint'(WINDOW_LEN) - 1) / longint'(WINDOW_LEN);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

    logic [PROD_W-1:0] prod;

    // Reciprocal is rounded up; exact floor for every sum below 2**SUM_W.
    always_comb
    begin
        prod = PROD_W'(sum) * PROD_W'(RECIP);
        quot = prod[SHIFT_K +: SAMPLE_W];
    end

endmodule

>>> rtl/core/pedal_rolling_average.sv
// Top level of the pedal rolling-average filter.
//
// Input channel: one 10-bit pedal sample per beat (sample_valid / sample_stall).
// Output channel: one 10-bit throttle value per input beat, in order
// (throttle_valid / throttle_stall). Throttle is the floor of the mean of the
// last WINDOW_LEN samples, this one included, taken before any refill.
// Configuration: cfg_we writes cfg_wdata into the release floor; write it only
// while no beat is in flight.
// Throughput: one beat per cycle while the receiver does not stall; three register
// stages (input, running sum, output) each advance whenever the stage ahead is
// empty or moving, and a sample reaches throttle through them in that order.
// When the receiver stalls, the output holds its beat and the stages behind it
// keep filling; sample_stall rises only once all three hold a beat.
// A run of LOW_RUN_LIMIT samples at or below the floor refills the whole window
// with the floor, so the next beat averages over that floor-filled window.
// Reset clears the window, the running sum, the run counter, the floor and
// every stage's valid flag.
module pedal_rolling_average #(
    parameter int WINDOW_LEN = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  pra_pkg::sample_t cfg_wdata,
    input  logic             sample_valid,
    output logic             sample_stall,
    input  pra_pkg::sample_t sample,
    output logic             throttle_valid,
    input  logic             throttle_stall,
    output pra_pkg::sample_t throttle
);
    import pra_pkg::*;

    localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_LEN);

    // Stage registers
    logic             s1_valid_reg, s1_valid_next;
    sample_t          s1_sample_reg, s1_sample_next;
    logic             s2_valid_reg, s2_valid_next;
    logic [SUM_W-1:0] s2_sum_reg, s2_sum_next;
    logic             s3_valid_reg, s3_valid_next;
    sample_t          s3_throttle_reg, s3_throttle_next;
    sample_t          floor_reg, floor_next;

    logic             adv1, adv2, adv3;
    pra_win_ctrl_t    win_ctrl;
    logic [SUM_W-1:0] sum_pre;
    sample_t          quot;

    // Each stage advances when the one ahead is empty or advancing.
    always_comb
    begin
        adv3 = !s3_valid_reg || !throttle_stall;
        adv2 = !s2_valid_reg || adv3;
        adv1 = !s1_valid_reg || adv2;
        sample_stall = !adv1;
    end

    // The window updates as the sample moves from stage 1 to stage 2.
    always_comb
    begin
        win_ctrl.load   = s1_valid_reg && adv2;
        win_ctrl.sample = s1_sample_reg;
    end

    pra_window #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (win_ctrl),
        .floor_val (floor_reg),
        .sum_pre   (sum_pre)
    );

    pra_div #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_div (
        .sum  (s2_sum_reg),
        .quot (quot)
    );

    always_comb
    begin
        floor_next       = cfg_we ? cfg_wdata : floor_reg;
        s1_valid_next    = adv1 ? sample_valid : s1_valid_reg;
        s1_sample_next   = (adv1 && sample_valid) ? sample : s1_sample_reg;
        s2_valid_next    = adv2 ? s1_valid_reg : s2_valid_reg;
        s2_sum_next      = (adv2 && s1_valid_reg) ? sum_pre : s2_sum_reg;
        s3_valid_next    = adv3 ? s2_valid_reg : s3_valid_reg;
        s3_throttle_next = (adv3 && s2_valid_reg) ? quot : s3_throttle_reg;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg    <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            floor_reg    <= floor_next;
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    // Payload: no reset needed
    always_ff @(posedge clk)
    begin
        s1_sample_reg   <= s1_sample_next;
        s2_sum_reg      <= s2_sum_next;
        s3_throttle_reg <= s3_throttle_next;
    end

    assign throttle_valid = s3_valid_reg;
    assign throttle       = s3_throttle_reg;

endmodule

>>> rtl/core/pra_checker.sv
// Port-level checker for the pedal rolling-average filter, with its bind.
module pra_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             sample_valid,
    input logic             sample_stall,
    input logic             throttle_valid,
    input logic             throttle_stall,
    input pra_pkg::sample_t throttle
);
    import pra_pkg::*;

    logic [2:0] occ_reg, occ_next;
    logic       in_beat, out_beat;

    // Count beats in flight: accepted but not yet delivered.
    always_comb
    begin
        in_beat  = sample_valid && !sample_stall;
        out_beat = throttle_valid && !throttle_stall;
        occ_next = occ_reg + {2'b00, in_beat} - {2'b00, out_beat};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        throttle_valid && throttle_stall |=> throttle_valid && $stable(throttle))
        else $error("stalled throttle beat changed");

    a_free_out_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !throttle_stall |-> !sample_stall)
        else $error("input stalled while output was free");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= 3'd3)
        else $error("more beats in flight than stages");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        throttle_valid |-> occ_reg != 3'd0)
        else $error("throttle beat with no sample in flight");

endmodule

bind pedal_rolling_average pra_checker u_pra_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .sample_valid   (sample_valid),
    .sample_stall   (sample_stall),
    .throttle_valid (throttle_valid),
    .throttle_stall (throttle_stall),
    .throttle       (throttle)
);
